// ===== hw/rtl/tcw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tcw_pkg;

  localparam int KIND_W    = 2;
  localparam int CODE_W    = 8;
  localparam int ADDR_IN_W = 11;
  localparam int OFF_W     = 11;
  localparam int CELL_W    = 16;

  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  localparam logic [CODE_W-1:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [CODE_W-1:0] CHAR_TAB       = 8'h09;
  localparam logic [CODE_W-1:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [CODE_W-1:0] CHAR_SPACE     = 8'h20;
  localparam logic [CODE_W-1:0] CHAR_PRINT_LO  = 8'h20;
  localparam logic [CODE_W-1:0] CHAR_PRINT_HI  = 8'h7E;

  localparam int TAB_STOP = 4;

  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_DEPTH = 1 << QUEUE_PTR_W;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_PRINT,
    OP_TAB,
    OP_NEWLINE,
    OP_BACKSPACE,
    OP_CLEAR,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [CODE_W-1:0]    code;
    logic [ADDR_IN_W-1:0] addr;
  } op_item_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_TAB,
    ST_SCROLL,
    ST_CLEAR,
    ST_READ
  } st_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tcw_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tcw_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tcw_front #(
  parameter int CELLS = 2000
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [tcw_pkg::KIND_W-1:0]        in_kind,
  input  wire logic [tcw_pkg::CODE_W-1:0]        in_char_code,
  input  wire logic [tcw_pkg::ADDR_IN_W-1:0]     in_cell_address,
  input  wire logic                              hold,
  input  wire logic                              q_full,
  output logic                                   q_push,
  output tcw_pkg::op_item_t                      q_item
);

  logic              fr_valid_r, fr_valid_nxt;
  tcw_pkg::op_item_t fr_item_r, fr_item_nxt;
  logic              accept;
  tcw_pkg::op_t      op_cls;

  assign in_stall = hold || (fr_valid_r && q_full);
  assign accept   = in_valid && !in_stall;
  assign q_push   = fr_valid_r && !q_full;
  assign q_item   = fr_item_r;

  always_comb begin
    op_cls = tcw_pkg::OP_NOP;
    case (in_kind)
      tcw_pkg::KIND_PUT: begin
        if (in_char_code == tcw_pkg::CHAR_TAB) begin
          op_cls = tcw_pkg::OP_TAB;
        end else if (in_char_code == tcw_pkg::CHAR_NEWLINE) begin
          op_cls = tcw_pkg::OP_NEWLINE;
        end else if (in_char_code == tcw_pkg::CHAR_BACKSPACE) begin
          op_cls = tcw_pkg::OP_BACKSPACE;
        end else if (in_char_code inside {[tcw_pkg::CHAR_PRINT_LO:tcw_pkg::CHAR_PRINT_HI]}) begin
          op_cls = tcw_pkg::OP_PRINT;
        end
      end
      tcw_pkg::KIND_CLEAR: begin
        op_cls = tcw_pkg::OP_CLEAR;
      end
      tcw_pkg::KIND_READ: begin
        if (32'(in_cell_address) < CELLS) begin
          op_cls = tcw_pkg::OP_READ;
        end
      end
      default: begin
        op_cls = tcw_pkg::OP_NOP;
      end
    endcase
  end

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    fr_item_nxt  = fr_item_r;
    if (accept) begin
      fr_valid_nxt     = 1'b1;
      fr_item_nxt.op   = op_cls;
      fr_item_nxt.code = in_char_code;
      fr_item_nxt.addr = in_cell_address;
    end else if (q_push) begin
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
    fr_item_r <= fr_item_nxt;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tcw_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tcw_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire tcw_pkg::op_item_t push_item,
  output logic                   full,
  input  wire logic              pop,
  output logic                   pop_valid,
  output tcw_pkg::op_item_t      pop_item
);

  localparam int PW = tcw_pkg::QUEUE_PTR_W;

  tcw_pkg::op_item_t mem_r [tcw_pkg::QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]       count_r, count_nxt;

  assign full      = (count_r == (PW+1)'(tcw_pkg::QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tcw_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [tcw_pkg::CELL_W-1:0]    style,
  input  wire logic                          q_valid,
  input  wire tcw_pkg::op_item_t             q_item,
  output logic                               q_pop,
  output logic                               init_busy,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [tcw_pkg::OFF_W-1:0]          out_cursor_offset,
  output logic [tcw_pkg::CELL_W-1:0]         out_read_data
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int OFFC_W = (ADDR_W > tcw_pkg::OFF_W) ? ADDR_W : tcw_pkg::OFF_W;
  localparam int CW     = tcw_pkg::CELL_W;

  tcw_pkg::st_t         state_r, state_nxt;
  logic [COL_W-1:0]     col_r, col_nxt;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [tcw_pkg::OFF_W-1:0] out_off_r;
  logic [CW-1:0]        out_data_r;

  logic                 load;
  logic [CW-1:0]        load_data;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [CW-1:0]        wr_data;
  logic [ADDR_W-1:0]    rd_addr;
  logic [CW-1:0]        rd_data;

  logic [ADDR_W-1:0]    cur_addr;
  logic                 last_col, last_row;
  logic [COL_W-1:0]     col_step;
  logic [ROW_W-1:0]     row_step, row_down;
  logic                 scroll_step, tab_done, out_free;
  logic [CNT_W-1:0]     cnt_m1, cnt_up;
  logic [OFFC_W-1:0]    nxt_off;
  logic [CW-1:0]        char_cell, space_cell;

  tcw_ram #(
    .WIDTH (CW),
    .DEPTH (CELLS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign cur_addr    = ADDR_W'(row_r) * ADDR_W'(COLUMNS) + ADDR_W'(col_r);
  assign last_col    = (col_r == COL_W'(COLUMNS - 1));
  assign last_row    = (row_r == ROW_W'(ROWS - 1));
  assign row_down    = last_row ? row_r : row_r + 1'b1;
  assign col_step    = last_col ? '0 : col_r + 1'b1;
  assign row_step    = last_col ? row_down : row_r;
  assign scroll_step = last_col && last_row;
  assign tab_done    = ((col_step % COL_W'(tcw_pkg::TAB_STOP)) == '0);
  assign cnt_m1      = cnt_r - 1'b1;
  assign cnt_up      = cnt_r + CNT_W'(COLUMNS);
  assign nxt_off     = OFFC_W'(row_nxt) * OFFC_W'(COLUMNS) + OFFC_W'(col_nxt);
  assign char_cell   = style | {{(CW - tcw_pkg::CODE_W){1'b0}}, q_item.code};
  assign space_cell  = style | {{(CW - tcw_pkg::CODE_W){1'b0}}, tcw_pkg::CHAR_SPACE};
  assign out_free    = !out_valid_r || !out_stall;

  assign init_busy         = (state_r == tcw_pkg::ST_INIT);
  assign out_valid         = out_valid_r;
  assign out_cursor_offset = out_off_r;
  assign out_read_data     = out_data_r;

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    cnt_nxt   = cnt_r;
    load      = 1'b0;
    load_data = '0;
    q_pop     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = cur_addr;
    wr_data   = style;
    rd_addr   = '0;
    case (state_r)
      tcw_pkg::ST_INIT: begin
        wr_en   = 1'b1;
        wr_addr = cnt_r[ADDR_W-1:0];
        wr_data = '0;
        if (cnt_r == CNT_W'(CELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = tcw_pkg::ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          case (q_item.op)
            tcw_pkg::OP_PRINT: begin
              wr_en   = 1'b1;
              wr_data = char_cell;
              col_nxt = col_step;
              row_nxt = row_step;
              if (scroll_step) begin
                cnt_nxt   = '0;
                state_nxt = tcw_pkg::ST_SCROLL;
              end else begin
                load = 1'b1;
              end
            end
            tcw_pkg::OP_TAB: begin
              wr_en   = 1'b1;
              wr_data = space_cell;
              col_nxt = col_step;
              row_nxt = row_step;
              if (scroll_step) begin
                cnt_nxt   = '0;
                state_nxt = tcw_pkg::ST_SCROLL;
              end else if (tab_done) begin
                load = 1'b1;
              end else begin
                state_nxt = tcw_pkg::ST_TAB;
              end
            end
            tcw_pkg::OP_NEWLINE: begin
              col_nxt = '0;
              row_nxt = row_down;
              if (last_row) begin
                cnt_nxt   = '0;
                state_nxt = tcw_pkg::ST_SCROLL;
              end else begin
                load = 1'b1;
              end
            end
            tcw_pkg::OP_BACKSPACE: begin
              if (col_r != '0) begin
                col_nxt = col_r - 1'b1;
                wr_en   = 1'b1;
                wr_addr = cur_addr - 1'b1;
              end
              load = 1'b1;
            end
            tcw_pkg::OP_CLEAR: begin
              cnt_nxt   = '0;
              state_nxt = tcw_pkg::ST_CLEAR;
            end
            tcw_pkg::OP_READ: begin
              rd_addr   = ADDR_W'(q_item.addr);
              state_nxt = tcw_pkg::ST_READ;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      tcw_pkg::ST_TAB: begin
        wr_en   = 1'b1;
        wr_data = space_cell;
        col_nxt = col_step;
        row_nxt = row_step;
        if (scroll_step) begin
          cnt_nxt   = '0;
          state_nxt = tcw_pkg::ST_SCROLL;
        end else if (tab_done) begin
          load      = 1'b1;
          state_nxt = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_SCROLL: begin
        if (cnt_r < CNT_W'(CELLS - COLUMNS)) begin
          rd_addr = cnt_up[ADDR_W-1:0];
        end
        if (cnt_r != '0) begin
          wr_en   = 1'b1;
          wr_addr = cnt_m1[ADDR_W-1:0];
          wr_data = (cnt_m1 < CNT_W'(CELLS - COLUMNS)) ? rd_data : style;
        end
        if (cnt_r == CNT_W'(CELLS)) begin
          cnt_nxt   = '0;
          load      = 1'b1;
          state_nxt = tcw_pkg::ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      tcw_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt_r[ADDR_W-1:0];
        wr_data = style;
        if (cnt_r == CNT_W'(CELLS - 1)) begin
          cnt_nxt   = '0;
          col_nxt   = '0;
          row_nxt   = '0;
          load      = 1'b1;
          state_nxt = tcw_pkg::ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      tcw_pkg::ST_READ: begin
        load      = 1'b1;
        load_data = rd_data;
        state_nxt = tcw_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tcw_pkg::ST_IDLE;
      end
    endcase
    out_valid_nxt = load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcw_pkg::ST_INIT;
      col_r       <= '0;
      row_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (load) begin
      out_off_r  <= nxt_off[tcw_pkg::OFF_W-1:0];
      out_data_r <= load_data;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/text_console_writer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Printable bytes, newline, backspace and ignored items pass the front register, the queue
// and the back end's output register; a read also passes the registered screen store read
// port; a tab writes spaces, up to 4. Throughput: 1 item per cycle for items that need no
// extra state, while out_stall is low. Scroll holds the back end (one store copy per cycle),
// and so does clear. Reset: synchronous, active low; afterwards a clearing pass zeroes the
// screen store while in_stall stays high.
module text_console_writer_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [tcw_pkg::CELL_W-1:0]    cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [tcw_pkg::KIND_W-1:0]    in_kind,
  input  wire logic [tcw_pkg::CODE_W-1:0]    in_char_code,
  input  wire logic [tcw_pkg::ADDR_IN_W-1:0] in_cell_address,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [tcw_pkg::OFF_W-1:0]          out_cursor_offset,
  output logic [tcw_pkg::CELL_W-1:0]         out_read_data
);

  localparam int CELLS = COLUMNS * ROWS;

  logic [tcw_pkg::CELL_W-1:0] style_r;
  logic                       init_busy;
  logic                       q_push, q_full, q_pop, q_valid;
  tcw_pkg::op_item_t          q_in_item, q_out_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      style_r <= '0;
    end else if (cfg_we) begin
      style_r <= cfg_wdata;
    end
  end

  tcw_front #(
    .CELLS (CELLS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_char_code    (in_char_code),
    .in_cell_address (in_cell_address),
    .hold            (init_busy),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_item          (q_in_item)
  );

  tcw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (q_out_item)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .style             (style_r),
    .q_valid           (q_valid),
    .q_item            (q_out_item),
    .q_pop             (q_pop),
    .init_busy         (init_busy),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cursor_offset (out_cursor_offset),
    .out_read_data     (out_read_data)
  );

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("queue push while full");

  a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue pop while empty");

  a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    init_busy |-> (in_stall && !out_valid))
    else $error("transfer during clearing pass");

  a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_cursor_offset) < CELLS))
    else $error("cursor offset beyond screen");

endmodule
`default_nettype wire

// ===== sim/text_console_writer_checker.sv =====
`timescale 1ns / 1ps
module text_console_writer_checker import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CELL_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [CODE_W-1:0]    in_char_code,
  input  logic [ADDR_IN_W-1:0] in_cell_address,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [OFF_W-1:0]     out_cursor_offset,
  input  logic [CELL_W-1:0]    out_read_data,
  output int                   fail_count,
  output int                   pending_count
);

  localparam int CELLS = COLUMNS * ROWS;

  typedef struct packed {
    logic [OFF_W-1:0]  cursor_offset;
    logic [CELL_W-1:0] read_data;
  } console_result_t;

  logic [CELL_W-1:0] style_q;
  logic [CELL_W-1:0] screen_model [CELLS];
  logic [6:0]        col_q;
  logic [4:0]        row_q;
  console_result_t   expected_results [$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  function automatic int cursor_index();
    return int'(row_q) * COLUMNS + int'(col_q);
  endfunction

  function automatic void fill_screen(input logic [CELL_W-1:0] v);
    for (int i = 0; i < CELLS; i++) screen_model[i] = v;
  endfunction

  function automatic void next_row();
    col_q = '0;
    if (int'(row_q) + 1 >= ROWS) begin
      for (int i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = style_q;
      row_q = 5'(ROWS - 1);
    end else begin
      row_q = row_q + 5'd1;
    end
  endfunction

  function automatic void put_glyph(input logic [CODE_W-1:0] c);
    screen_model[cursor_index()] = style_q | {{(CELL_W-CODE_W){1'b0}}, c};
    if (int'(col_q) + 1 >= COLUMNS) begin
      next_row();
    end else begin
      col_q = col_q + 7'd1;
    end
  endfunction

  function automatic void put_code(input logic [CODE_W-1:0] c);
    if (c == CHAR_TAB) begin
      do put_glyph(CHAR_SPACE); while ((int'(col_q) % TAB_STOP) != 0);
    end else if (c == CHAR_NEWLINE) begin
      next_row();
    end else if (c == CHAR_BACKSPACE) begin
      if (col_q != '0) begin
        col_q = col_q - 7'd1;
        screen_model[cursor_index()] = style_q;
      end
    end else if (c >= CHAR_PRINT_LO && c <= CHAR_PRINT_HI) begin
      put_glyph(c);
    end
  endfunction

  function automatic console_result_t predict_console(input logic [KIND_W-1:0]    k,
                                                      input logic [CODE_W-1:0]    c,
                                                      input logic [ADDR_IN_W-1:0] a);
    console_result_t r;
    r.read_data = '0;
    case (k)
      KIND_PUT: put_code(c);
      KIND_CLEAR: begin
        fill_screen(style_q);
        col_q = '0;
        row_q = '0;
      end
      KIND_READ: begin
        if (int'(a) < CELLS) r.read_data = screen_model[a];
      end
      default: ;
    endcase
    r.cursor_offset = OFF_W'(cursor_index());
    return r;
  endfunction

  always @(posedge clk) begin
    console_result_t want;
    if (!rst_n) begin
      style_q = '0;
      fill_screen('0);
      col_q = '0;
      row_q = '0;
      expected_results.delete();
    end else begin
      if (cfg_we) style_q = cfg_wdata;
      if (in_valid && !in_stall)
        expected_results.push_back(predict_console(in_kind, in_char_code, in_cell_address));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected transfer: expected none, got cursor_offset %0d read_data %h",
                   $time, out_cursor_offset, out_read_data);
        end else begin
          want = expected_results.pop_front();
          if (out_cursor_offset !== want.cursor_offset) begin
            fail_count++;
            $display("%0t: cursor_offset mismatch: expected %0d, got %0d",
                     $time, want.cursor_offset, out_cursor_offset);
          end
          if (out_read_data !== want.read_data) begin
            fail_count++;
            $display("%0t: read_data mismatch: expected %h, got %h",
                     $time, want.read_data, out_read_data);
          end
        end
      end
    end
    pending_count = expected_results.size();
  end

endmodule

// ===== sim/tb_text_console_writer_top.sv =====
`timescale 1ns / 1ps
module tb_text_console_writer_top;
  import tcw_pkg::*;

  localparam int COLUMNS        = 80;
  localparam int ROWS           = 25;
  localparam int CELLS          = COLUMNS * ROWS;
  localparam int ADDR_MAX       = (1 << ADDR_IN_W) - 1;
  localparam int SETTLE_CYCLES  = CELLS + 16;
  localparam int HOLDOFF_CYCLES = 64;
  localparam int STALL_LIMIT    = 20000;
  localparam int PHASE_ITEMS    = 120;
  localparam int PHASES         = 5;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CELL_W-1:0]    cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [KIND_W-1:0]    in_kind;
  logic [CODE_W-1:0]    in_char_code;
  logic [ADDR_IN_W-1:0] in_cell_address;
  logic                 out_valid;
  logic                 out_stall;
  logic [OFF_W-1:0]     out_cursor_offset;
  logic [CELL_W-1:0]    out_read_data;

  int fail_count;
  int pending_count;
  int items_sent   = 0;
  int last_offset  = 0;
  int quiet_cycles = 0;
  bit sender_gaps;
  bit receiver_gaps;
  bit holdoff_req;

  text_console_writer_top #(.COLUMNS(COLUMNS), .ROWS(ROWS)) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_char_code      (in_char_code),
    .in_cell_address   (in_cell_address),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cursor_offset (out_cursor_offset),
    .out_read_data     (out_read_data)
  );

  text_console_writer_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_char_code      (in_char_code),
    .in_cell_address   (in_cell_address),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cursor_offset (out_cursor_offset),
    .out_read_data     (out_read_data),
    .fail_count        (fail_count),
    .pending_count     (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_req) begin
        out_stall <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        holdoff_req = 1'b0;
        out_stall <= 1'b0;
      end else if (receiver_gaps && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 3);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (out_valid && !out_stall) last_offset <= int'(out_cursor_offset);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_text_console_writer_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic [KIND_W-1:0]    k,
                           input logic [CODE_W-1:0]    c,
                           input logic [ADDR_IN_W-1:0] a);
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= k;
    in_char_code    <= c;
    in_cell_address <= a;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic put_char(input logic [CODE_W-1:0] c);
    send_item(KIND_PUT, c, ADDR_IN_W'($urandom_range(0, ADDR_MAX)));
  endtask

  task automatic read_cell(input logic [ADDR_IN_W-1:0] a);
    send_item(KIND_READ, CODE_W'($urandom_range(0, 255)), a);
  endtask

  task automatic write_style(input logic [CELL_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_count == 0);
  endtask

  function automatic logic [CODE_W-1:0] line_char();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return CODE_W'($urandom_range(CHAR_PRINT_LO, CHAR_PRINT_HI));
    if (pick < 87) return CHAR_TAB;
    if (pick < 94) return CHAR_BACKSPACE;
    return CODE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [ADDR_IN_W-1:0] pick_address();
    int pick;
    int a;
    pick = $urandom_range(0, 99);
    if (pick < 15) return ADDR_IN_W'($urandom_range(CELLS, ADDR_MAX));
    if (pick < 35) return ADDR_IN_W'($urandom_range(0, CELLS - 1));
    a = last_offset - int'($urandom_range(0, 2 * COLUMNS));
    if (a < 0) a = $urandom_range(0, COLUMNS - 1);
    return ADDR_IN_W'(a);
  endfunction

  task automatic text_line(input int len);
    for (int i = 0; i < len; i++) put_char(line_char());
    if ($urandom_range(0, 9) != 0) put_char(CHAR_NEWLINE);
  endtask

  task automatic run_phase(input int p);
    int               target;
    int               pick;
    bit               paused;
    logic [KIND_W-1:0] k;
    target = items_sent + PHASE_ITEMS;
    paused = 1'b0;
    if (p == 1) begin
      holdoff_req = 1'b1;
      sender_gaps = 1'b0;
      text_line(40);
      sender_gaps = 1'b1;
    end
    while (items_sent < target) begin
      if (p == 2 && !paused && items_sent >= target - PHASE_ITEMS / 2) begin
        drain_results();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        text_line($urandom_range(3, 90));
      end else if (pick < 75) begin
        repeat ($urandom_range(4, 10)) read_cell(pick_address());
      end else if (pick < 85) begin
        repeat ($urandom_range(2, 10)) put_char(CHAR_NEWLINE);
      end else if (pick < 95) begin
        repeat ($urandom_range(5, 15)) begin
          k = KIND_W'($urandom_range(0, 3));
          if (k == KIND_CLEAR && $urandom_range(0, 3) != 0) k = KIND_READ;
          send_item(k, CODE_W'($urandom_range(0, 255)), ADDR_IN_W'($urandom_range(0, ADDR_MAX)));
        end
      end else begin
        send_item(KIND_CLEAR, CODE_W'($urandom_range(0, 255)),
                  ADDR_IN_W'($urandom_range(0, ADDR_MAX)));
      end
    end
  endtask

  initial begin
    logic [CELL_W-1:0] styles [PHASES];
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_kind         = KIND_PUT;
    in_char_code    = '0;
    in_cell_address = '0;
    sender_gaps     = 1'b1;
    receiver_gaps   = 1'b1;
    holdoff_req     = 1'b0;
    styles[0] = 16'hFFFF;
    styles[1] = 16'h0000;
    styles[2] = CELL_W'($urandom);
    styles[3] = 16'h1E00;
    styles[4] = CELL_W'($urandom);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_style(16'h0700);

    read_cell(ADDR_IN_W'(0));
    read_cell(ADDR_IN_W'(CELLS - 1));
    read_cell(ADDR_IN_W'(ADDR_MAX));
    put_char(8'h41);
    put_char(CHAR_PRINT_LO);
    put_char(CHAR_PRINT_HI);
    put_char(8'h7F);
    put_char(8'hFF);
    put_char(8'h00);
    put_char(CHAR_BACKSPACE);
    put_char(CHAR_TAB);
    put_char(CHAR_TAB);
    read_cell(ADDR_IN_W'(2));
    read_cell(ADDR_IN_W'(5));
    put_char(CHAR_NEWLINE);
    put_char(CHAR_BACKSPACE);
    send_item(KIND_UNUSED, 8'hFF, ADDR_IN_W'(ADDR_MAX));
    send_item(KIND_UNUSED, 8'h00, '0);
    read_cell(ADDR_IN_W'(1));
    send_item(KIND_CLEAR, 8'hAA, ADDR_IN_W'(ADDR_MAX));
    read_cell(ADDR_IN_W'(5));
    read_cell(ADDR_IN_W'(CELLS));

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clk);
      write_style(styles[p]);
      if (p == PHASES - 1) begin
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
      end
      run_phase(p);
    end

    drain_results();
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_text_console_writer_top passed");
    end else begin
      $display("tb_text_console_writer_top failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ram.sv
hw/rtl/tcw_front.sv
hw/rtl/tcw_queue.sv
hw/rtl/tcw_back.sv
hw/rtl/text_console_writer_top.sv
sim/text_console_writer_checker.sv
sim/tb_text_console_writer_top.sv
